/* hdl/lztd_pkg.sv */
`default_nettype none
package lztd_pkg;

    localparam int WINDOW_BYTES = 512;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);
    localparam int FILL_W       = WIN_AW + 1;
    localparam int OUT_LANES    = 4;
    localparam int LANE_W       = $clog2(OUT_LANES);
    localparam int DATA_W       = OUT_LANES * 8;
    localparam int CNT_W        = 3;
    localparam int TOK_W        = 17;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int LEN_W        = 8;
    localparam int MIN_COPY     = 3;

    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;
    localparam logic [1:0] PH_IDLE = 2'd3;

    localparam logic [1:0] SRC_LIT    = 2'd0;
    localparam logic [1:0] SRC_ZERO   = 2'd1;
    localparam logic [1:0] SRC_RECENT = 2'd2;
    localparam logic [1:0] SRC_RAM    = 2'd3;

    typedef struct packed {
        logic [TOK_W-1:0] tok;
        logic             first;
        logic             final_tok;
    } t_tok;

endpackage
`default_nettype wire

/* hdl/lztd_ram.sv */
`default_nettype none
module lztd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hdl/lztd_front.sv */
`default_nettype none
module lztd_front
    import lztd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [15:0] i_word,
    input  wire logic        i_start,
    input  wire logic        i_q_ready,
    output logic             o_ready,
    output logic             o_push,
    output t_tok             o_tok
);

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_count_high, n_count_high;
    logic [30:0] r_tokens_left, n_tokens_left;
    logic [31:0] r_buf, n_buf;
    logic [5:0]  r_held, n_held;
    logic        r_first, n_first;

    logic        accept;
    logic [31:0] wide;
    logic [5:0]  held16;
    logic [4:0]  h2;
    logic [31:0] count;
    logic        final_tok;

    assign o_ready   = i_q_ready;
    assign accept    = i_valid && i_q_ready;
    assign wide      = {r_buf[15:0], i_word};
    assign held16    = r_held + 6'd16;
    assign h2        = 5'(held16 - 6'd17);
    assign count     = {r_count_high, i_word};
    assign final_tok = (r_tokens_left == 31'd1);

    assign o_tok.tok       = TOK_W'(wide >> h2);
    assign o_tok.first     = r_first;
    assign o_tok.final_tok = final_tok;

    always_comb begin
        n_phase       = r_phase;
        n_count_high  = r_count_high;
        n_tokens_left = r_tokens_left;
        n_buf         = r_buf;
        n_held        = r_held;
        n_first       = r_first;
        o_push        = 1'b0;
        if (accept) begin
            if (i_start || r_phase == PH_HIGH) begin
                n_buf         = '0;
                n_held        = '0;
                n_tokens_left = '0;
                n_count_high  = i_word;
                n_phase       = PH_LOW;
                n_first       = 1'b1;
            end else if (r_phase == PH_LOW) begin
                if (count == 32'd0 || count[31]) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_tokens_left = count[30:0];
                    n_buf         = '0;
                    n_held        = '0;
                    n_phase       = PH_RUN;
                end
            end else if (r_phase == PH_RUN) begin
                if (held16 >= 6'd17) begin
                    o_push        = 1'b1;
                    n_held        = 6'(h2);
                    n_buf         = wide & ~(32'hFFFF_FFFF << h2);
                    n_first       = 1'b0;
                    n_tokens_left = r_tokens_left - 31'd1;
                    if (final_tok) begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_buf  = wide;
                    n_held = held16;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HIGH;
            r_count_high  <= '0;
            r_tokens_left <= '0;
            r_buf         <= '0;
            r_held        <= '0;
            r_first       <= 1'b1;
        end else begin
            r_phase       <= n_phase;
            r_count_high  <= n_count_high;
            r_tokens_left <= n_tokens_left;
            r_buf         <= n_buf;
            r_held        <= n_held;
            r_first       <= n_first;
        end
    end

endmodule
`default_nettype wire

/* hdl/lztd_queue.sv */
`default_nettype none
module lztd_queue
    import lztd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_tok i_tok,
    output logic      o_ready,
    output logic      o_valid,
    output t_tok      o_tok,
    input  wire logic i_pop
);

    t_tok                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_slot[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/lztd_back.sv */
`default_nettype none
module lztd_back
    import lztd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_tok        i_q_tok,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [DATA_W-1:0] o_data,
    output logic [CNT_W-1:0] o_count,
    output logic             o_last,
    output logic             o_eoi
);

    // Issue side: token registers and write pointer / fill level.
    logic              r_a_act;
    logic [1:0]        r_a_mode;
    logic [15:0]       r_a_lit;
    logic [WIN_AW-1:0] r_a_src;
    logic [LEN_W-1:0]  r_a_left;
    logic              r_a_final;
    logic [WIN_AW-1:0] r_wp;
    logic [FILL_W-1:0] r_fill;

    // Write side: one byte per beat of the pipeline.
    logic              r_b_vld;
    logic [1:0]        r_b_mode;
    logic [7:0]        r_b_lit;
    logic [WIN_AW-1:0] r_b_waddr;
    logic              r_b_last;
    logic              r_b_final;
    logic              r_b_cap;
    logic [7:0]        r_b_hold;
    logic [7:0]        r_recent;

    logic [LANE_W-1:0] r_pk_cnt;
    logic [DATA_W-1:0] r_pk_data;

    logic              r_o_vld;
    logic [DATA_W-1:0] r_o_data;
    logic [CNT_W-1:0]  r_o_cnt;
    logic              r_o_last;
    logic              r_o_eoi;

    logic              load;
    logic              issue;
    logic              b_go;
    logic              flush;
    logic              out_free;
    logic [7:0]        b_byte;
    logic [7:0]        ram_rdata;
    logic [DATA_W-1:0] pk_next;

    logic [WIN_AW-1:0] wp_eff;
    logic [FILL_W-1:0] fill_eff;
    logic [WIN_AW-1:0] off;
    logic              src_ok;
    logic [FILL_W-1:0] src_gap;
    logic [1:0]        copy_mode;

    assign load    = !r_a_act && i_q_valid;
    assign o_q_pop = load;

    assign wp_eff    = i_q_tok.first ? '0 : r_wp;
    assign fill_eff  = i_q_tok.first ? '0 : r_fill;
    assign off       = i_q_tok.tok[15:7];
    assign src_ok    = {1'b0, off} < fill_eff;
    assign src_gap   = fill_eff - {1'b0, off};
    assign copy_mode = !src_ok ? SRC_ZERO :
                       (src_gap == FILL_W'(1)) ? SRC_RECENT : SRC_RAM;

    assign out_free = !r_o_vld || i_ready;
    assign flush    = r_b_last || (r_pk_cnt == LANE_W'(OUT_LANES - 1));
    assign b_go     = r_b_vld && (!flush || out_free);
    assign issue    = r_a_act && (!r_b_vld || b_go);

    always_comb begin
        case (r_b_mode)
            SRC_LIT:    b_byte = r_b_lit;
            SRC_ZERO:   b_byte = 8'd0;
            SRC_RECENT: b_byte = r_recent;
            SRC_RAM:    b_byte = r_b_cap ? r_b_hold : ram_rdata;
            default:    b_byte = 8'd0;
        endcase
    end

    assign pk_next = r_pk_data | (DATA_W'(b_byte) << {r_pk_cnt, 3'b000});

    lztd_ram #(
        .WIDTH(8),
        .DEPTH(WINDOW_BYTES)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (b_go),
        .i_waddr(r_b_waddr),
        .i_wdata(b_byte),
        .i_raddr(r_a_src),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a_final <= i_q_tok.final_tok;
            r_a_lit   <= i_q_tok.tok[15:0];
            r_a_src   <= wp_eff - src_gap[WIN_AW-1:0];
            if (i_q_tok.tok[16]) begin
                r_a_mode <= SRC_LIT;
                r_a_left <= LEN_W'(2);
            end else begin
                r_a_mode <= copy_mode;
                r_a_left <= LEN_W'(i_q_tok.tok[6:0]) + LEN_W'(MIN_COPY);
            end
        end else if (issue) begin
            r_a_lit  <= {r_a_lit[7:0], 8'd0};
            r_a_src  <= r_a_src + 1'b1;
            r_a_left <= r_a_left - 1'b1;
        end
        if (issue) begin
            r_b_mode  <= r_a_mode;
            r_b_lit   <= r_a_lit[15:8];
            r_b_waddr <= r_wp;
            r_b_last  <= (r_a_left == LEN_W'(1));
            r_b_final <= r_a_final;
        end
        if (r_b_vld && !b_go) begin
            r_b_hold <= b_byte;
        end
        if (b_go) begin
            r_recent <= b_byte;
        end
        if (b_go && flush && out_free) begin
            r_o_data <= pk_next;
            r_o_cnt  <= CNT_W'(r_pk_cnt) + CNT_W'(1);
            r_o_last <= r_b_last;
            r_o_eoi  <= r_b_last && r_b_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_act   <= 1'b0;
            r_wp      <= '0;
            r_fill    <= '0;
            r_b_vld   <= 1'b0;
            r_b_cap   <= 1'b0;
            r_pk_cnt  <= '0;
            r_pk_data <= '0;
            r_o_vld   <= 1'b0;
        end else begin
            if (load) begin
                r_a_act <= 1'b1;
                r_wp    <= wp_eff;
                r_fill  <= fill_eff;
            end else if (issue) begin
                r_a_act <= (r_a_left != LEN_W'(1));
                r_wp    <= r_wp + 1'b1;
                if (r_fill != FILL_W'(WINDOW_BYTES)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (issue) begin
                r_b_vld <= 1'b1;
            end else if (b_go) begin
                r_b_vld <= 1'b0;
            end
            r_b_cap <= r_b_vld && !b_go;
            if (b_go) begin
                if (flush) begin
                    r_pk_cnt  <= '0;
                    r_pk_data <= '0;
                end else begin
                    r_pk_cnt  <= r_pk_cnt + 1'b1;
                    r_pk_data <= pk_next;
                end
            end
            if (b_go && flush) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;
    assign o_count = r_o_cnt;
    assign o_last  = r_o_last;
    assign o_eoi   = r_o_eoi;

endmodule
`default_nettype wire

/* hdl/lz_token_decompressor.sv */
// A completed token goes through the token queue, the issue registers, the write stage
// and the packer into the output register that drives o_m_tvalid. The history RAM write
// port handles one byte per cycle while the output is not stalled; a new token loads only
// after the previous one has issued its last byte. A four-token queue between the word
// parser and copy engine stalls input when full. Reset (i_rst_n low, synchronous) clears
// the parser, queue, copy engine and output register; the history RAM is not cleared.
`default_nettype none
module lz_token_decompressor
    import lztd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // word_in
    input  wire logic        i_s_tuser,   // start_req
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // data_bytes [31:0], byte_count [34:32], zeros
    output logic             o_m_tlast,   // last_of_run
    output logic             o_m_tuser    // end_of_image
);

    t_tok              push_tok;
    t_tok              q_tok;
    logic              push;
    logic              q_ready;
    logic              q_valid;
    logic              q_pop;
    logic [DATA_W-1:0] out_data;
    logic [CNT_W-1:0]  out_cnt;

    lztd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_word   (i_s_tdata),
        .i_start  (i_s_tuser),
        .i_q_ready(q_ready),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_tok    (push_tok)
    );

    lztd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_tok  (push_tok),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_tok  (q_tok),
        .i_pop  (q_pop)
    );

    lztd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_tok  (q_tok),
        .o_q_pop  (q_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (out_data),
        .o_count  (out_cnt),
        .o_last   (o_m_tlast),
        .o_eoi    (o_m_tuser)
    );

    assign o_m_tdata = {5'd0, out_cnt, out_data};

endmodule
`default_nettype wire
